// ===== rtl/sia_pkg.sv =====
`timescale 1ns / 1ps
// sia_pkg: operation codes, stage counts and shared types of the signed interval ALU.
// No dependencies.
package sia_pkg;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_MOD = 4'd4;
  localparam logic [3:0] OP_EQ  = 4'd5;
  localparam logic [3:0] OP_NE  = 4'd6;
  localparam logic [3:0] OP_GT  = 4'd7;
  localparam logic [3:0] OP_GE  = 4'd8;
  localparam logic [3:0] OP_LT  = 4'd9;
  localparam logic [3:0] OP_LE  = 4'd10;
  localparam logic [3:0] OP_NEG = 4'd11;
  localparam logic [3:0] OP_NOT = 4'd12;

  localparam logic signed [63:0] S64_MIN = {1'b1, 63'd0};
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};

  localparam int DIV_STAGES = 64;
  localparam int MUL_STAGES = 4;
  // input reg, decode, divider, sign fix, pair span, output
  localparam int NSTG = DIV_STAGES + 5;

  typedef enum logic [1:0] {
    SEL_FIXED,
    SEL_MUL,
    SEL_DIV,
    SEL_REM
  } sel_t;

  typedef struct packed {
    sel_t              sel;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    logic              bot;
    logic [3:0]        qsgn;
    logic              rsgn;
  } sb_t;

endpackage

// ===== rtl/signed_interval_alu.sv =====
`timescale 1ns / 1ps
// signed_interval_alu: top level of the signed 64-bit interval ALU.
// Depends on sia_pkg, sia_mul, sia_div, sia_dly.
//
// Fully pipelined: one request is accepted every cycle unless a result stalls.
// There are 69 register stages (input register, decode, the 64-stage divider, three
// stages of sign fix, span and select) between a request and its result. A stall on
// the result side freezes the whole pipeline, so in_ready follows out_ready while a
// result waits.
module signed_interval_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_operation,
  input  logic signed [63:0] in_a_min,
  input  logic signed [63:0] in_a_max,
  input  logic signed [63:0] in_b_min,
  input  logic signed [63:0] in_b_max,
  input  logic               in_a_is_int,
  input  logic               in_b_is_int,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_result_min,
  output logic signed [63:0] out_result_max,
  output logic               out_is_bottom
);
  import sia_pkg::*;

  logic en;
  logic [NSTG-1:0] vld_r;

  assign en        = !vld_r[NSTG-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // input register
  logic [3:0]         op1_r;
  logic signed [63:0] al_r, ah_r, bl_r, bh_r;
  logic signed [63:0] al, ah, bl, bh;
  logic               ai1_r, bi1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= in_operation;
      al_r  <= in_a_min;
      ah_r  <= in_a_max;
      bl_r  <= in_b_min;
      bh_r  <= in_b_max;
      ai1_r <= in_a_is_int;
      bi1_r <= in_b_is_int;
    end
  end

  assign al = al_r;
  assign ah = ah_r;
  assign bl = bl_r;
  assign bh = bh_r;

  // decode
  logic signed [64:0] add_lo, add_hi, sub_lo, sub_hi;
  logic ah_lt_bl, al_gt_bh, ah_le_bl, al_ge_bh, aeq, beq, same, apart, unary, bot;
  logic signed [63:0] m_pos, m_neg;
  logic [63:0] mag_al, mag_ah, mag_bl, mag_bh;
  sb_t sb_nxt, sb_r;
  logic [63:0] mula_nxt [4], mulb_nxt [4];
  logic [3:0]  sgn_nxt;
  logic [63:0] mula_r [4], mulb_r [4];
  logic [3:0]  sgn_r;

  assign add_lo = {al[63], al} + {bl[63], bl};
  assign add_hi = {ah[63], ah} + {bh[63], bh};
  assign sub_lo = {al[63], al} - {bh[63], bh};
  assign sub_hi = {ah[63], ah} - {bl[63], bl};
  assign ah_lt_bl = ah < bl;
  assign al_gt_bh = al > bh;
  assign ah_le_bl = ah <= bl;
  assign al_ge_bh = al >= bh;
  assign aeq   = al == ah;
  assign beq   = bl == bh;
  assign same  = aeq && beq && (al == bl);
  assign apart = ah_lt_bl || al_gt_bh;
  assign unary = (op1_r == OP_NEG) || (op1_r == OP_NOT);
  assign bot   = (op1_r <= OP_NOT) && (!ai1_r || (!unary && !bi1_r));
  assign m_pos = bl[63] ? ~bl : bl - 64'sd1;
  assign m_neg = bl[63] ? bl + 64'sd1 : 64'sd1 - bl;
  assign mag_al = al[63] ? 64'd0 - al : al;
  assign mag_ah = ah[63] ? 64'd0 - ah : ah;
  assign mag_bl = bl[63] ? 64'd0 - bl : bl;
  assign mag_bh = bh[63] ? 64'd0 - bh : bh;

  assign mula_nxt[0] = mag_al;  assign mulb_nxt[0] = mag_bl;
  assign mula_nxt[1] = mag_al;  assign mulb_nxt[1] = mag_bh;
  assign mula_nxt[2] = mag_ah;  assign mulb_nxt[2] = mag_bl;
  assign mula_nxt[3] = mag_ah;  assign mulb_nxt[3] = mag_bh;
  assign sgn_nxt = {ah[63] ^ bh[63], ah[63] ^ bl[63], al[63] ^ bh[63], al[63] ^ bl[63]};

  always_comb begin
    sb_nxt      = '0;
    sb_nxt.sel  = SEL_FIXED;
    sb_nxt.lo   = S64_MIN;
    sb_nxt.hi   = S64_MAX;
    sb_nxt.qsgn = sgn_nxt;
    sb_nxt.rsgn = al[63];
    if (bot) begin
      sb_nxt.lo  = '0;
      sb_nxt.hi  = '0;
      sb_nxt.bot = 1'b1;
    end else begin
      case (op1_r)
        OP_ADD: begin
          if (!(add_lo[64] ^ add_lo[63]) && !(add_hi[64] ^ add_hi[63])) begin
            sb_nxt.lo = add_lo[63:0];
            sb_nxt.hi = add_hi[63:0];
          end
        end
        OP_SUB: begin
          if (!(sub_lo[64] ^ sub_lo[63]) && !(sub_hi[64] ^ sub_hi[63])) begin
            sb_nxt.lo = sub_lo[63:0];
            sb_nxt.hi = sub_hi[63:0];
          end
        end
        OP_MUL: sb_nxt.sel = SEL_MUL;
        OP_DIV: begin
          if (!((bl <= 0 && bh >= 0) || bl == 0 || bh == 0) &&
              !((al == S64_MIN || ah == S64_MIN) && (bl == -64'sd1 || bh == -64'sd1)))
            sb_nxt.sel = SEL_DIV;
        end
        OP_MOD: begin
          if (beq && bl != 0) begin
            if (aeq) begin
              if (bl == -64'sd1) begin
                sb_nxt.lo = '0;
                sb_nxt.hi = '0;
              end else begin
                sb_nxt.sel = SEL_REM;
              end
            end else if (!al[63]) begin
              sb_nxt.lo = '0;
              sb_nxt.hi = m_pos;
            end else if (ah <= 0) begin
              sb_nxt.lo = m_neg;
              sb_nxt.hi = '0;
            end else begin
              sb_nxt.lo = m_neg;
              sb_nxt.hi = m_pos;
            end
          end
        end
        OP_EQ: begin
          sb_nxt.lo = {63'd0, !apart && same};
          sb_nxt.hi = {63'd0, (!apart && same) || !apart};
        end
        OP_NE: begin
          sb_nxt.lo = {63'd0, apart};
          sb_nxt.hi = {63'd0, apart || !same};
        end
        OP_GT: begin
          sb_nxt.lo = {63'd0, al_gt_bh};
          sb_nxt.hi = {63'd0, al_gt_bh || !ah_le_bl};
        end
        OP_GE: begin
          sb_nxt.lo = {63'd0, al_ge_bh};
          sb_nxt.hi = {63'd0, al_ge_bh || !ah_lt_bl};
        end
        OP_LT: begin
          sb_nxt.lo = {63'd0, ah_lt_bl};
          sb_nxt.hi = {63'd0, ah_lt_bl || !al_ge_bh};
        end
        OP_LE: begin
          sb_nxt.lo = {63'd0, ah_le_bl};
          sb_nxt.hi = {63'd0, ah_le_bl || !al_gt_bh};
        end
        OP_NEG: begin
          if (al != S64_MIN && ah != S64_MIN) begin
            sb_nxt.lo = -ah;
            sb_nxt.hi = -al;
          end
        end
        OP_NOT: begin
          if (aeq) begin
            sb_nxt.lo = {63'd0, al == 0};
            sb_nxt.hi = {63'd0, al == 0};
          end else begin
            sb_nxt.lo = '0;
            sb_nxt.hi = 64'sd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r  <= sb_nxt;
      sgn_r <= sgn_nxt;
      for (int k = 0; k < 4; k++) begin
        mula_r[k] <= mula_nxt[k];
        mulb_r[k] <= mulb_nxt[k];
      end
    end
  end

  // arithmetic units
  logic signed [63:0] mp [4];
  logic [3:0]         mov;
  logic [63:0]        quo [4];
  logic [63:0]        rem0;

  for (genvar k = 0; k < 4; k++) begin : g_unit
    sia_mul u_mul (
      .clk   (clk),
      .en    (en),
      .a_i   (mula_r[k]),
      .b_i   (mulb_r[k]),
      .neg_i (sgn_r[k]),
      .p_o   (mp[k]),
      .ov_o  (mov[k])
    );
  end

  sia_div u_div0 (.clk(clk), .en(en), .n_i(mula_r[0]), .d_i(mulb_r[0]),
                  .q_o(quo[0]), .r_o(rem0));
  sia_div u_div1 (.clk(clk), .en(en), .n_i(mula_r[1]), .d_i(mulb_r[1]),
                  .q_o(quo[1]), .r_o());
  sia_div u_div2 (.clk(clk), .en(en), .n_i(mula_r[2]), .d_i(mulb_r[2]),
                  .q_o(quo[2]), .r_o());
  sia_div u_div3 (.clk(clk), .en(en), .n_i(mula_r[3]), .d_i(mulb_r[3]),
                  .q_o(quo[3]), .r_o());

  localparam int MWIDTH = 4 * 64 + 4;
  logic [MWIDTH-1:0] mpack, mpack_d;
  sb_t sbd;

  assign mpack = {mp[3], mp[2], mp[1], mp[0], mov};

  sia_dly #(.WIDTH(MWIDTH), .DEPTH(DIV_STAGES - MUL_STAGES)) u_mdly (
    .clk (clk), .en (en), .d_i (mpack), .q_o (mpack_d)
  );

  sia_dly #(.WIDTH($bits(sb_t)), .DEPTH(DIV_STAGES)) u_sdly (
    .clk (clk), .en (en), .d_i (sb_r), .q_o (sbd)
  );

  // sign fix and candidate select
  logic signed [63:0] qsv [4];
  logic signed [63:0] rv;
  logic signed [63:0] cand_nxt [4];
  logic span_nxt;
  logic signed [63:0] lo_nxt, hi_nxt;

  assign rv = sbd.rsgn ? -$signed(rem0) : $signed(rem0);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      qsv[k]      = sbd.qsgn[k] ? -$signed(quo[k]) : $signed(quo[k]);
      cand_nxt[k] = qsv[k];
    end
    span_nxt = 1'b0;
    lo_nxt   = sbd.lo;
    hi_nxt   = sbd.hi;
    case (sbd.sel)
      SEL_MUL: begin
        if (|mpack_d[3:0]) begin
          lo_nxt = S64_MIN;
          hi_nxt = S64_MAX;
        end else begin
          span_nxt = 1'b1;
          for (int k = 0; k < 4; k++) cand_nxt[k] = mpack_d[4 + 64*k +: 64];
        end
      end
      SEL_DIV: span_nxt = 1'b1;
      SEL_REM: begin
        span_nxt = 1'b1;
        for (int k = 0; k < 4; k++) cand_nxt[k] = rv;
      end
      default: ;
    endcase
  end

  logic signed [63:0] cand3_r [4];
  logic signed [63:0] lo3_r, hi3_r, lo4_r, hi4_r;
  logic span3_r, bot3_r, span4_r, bot4_r;
  logic signed [63:0] mn01_r, mx01_r, mn23_r, mx23_r;
  logic signed [63:0] res_min_r, res_max_r;
  logic res_bot_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) cand3_r[k] <= cand_nxt[k];
      span3_r <= span_nxt;
      lo3_r   <= lo_nxt;
      hi3_r   <= hi_nxt;
      bot3_r  <= sbd.bot;

      mn01_r  <= (cand3_r[1] < cand3_r[0]) ? cand3_r[1] : cand3_r[0];
      mx01_r  <= (cand3_r[1] > cand3_r[0]) ? cand3_r[1] : cand3_r[0];
      mn23_r  <= (cand3_r[3] < cand3_r[2]) ? cand3_r[3] : cand3_r[2];
      mx23_r  <= (cand3_r[3] > cand3_r[2]) ? cand3_r[3] : cand3_r[2];
      span4_r <= span3_r;
      lo4_r   <= lo3_r;
      hi4_r   <= hi3_r;
      bot4_r  <= bot3_r;

      res_min_r <= span4_r ? ((mn23_r < mn01_r) ? mn23_r : mn01_r) : lo4_r;
      res_max_r <= span4_r ? ((mx23_r > mx01_r) ? mx23_r : mx01_r) : hi4_r;
      res_bot_r <= bot4_r;
    end
  end

  assign out_result_min = res_min_r;
  assign out_result_max = res_max_r;
  assign out_is_bottom  = res_bot_r;

endmodule

// ===== rtl/sia_dly.sv =====
`timescale 1ns / 1ps
// sia_dly: enabled shift line that realigns side data with the divider.
// No dependencies.
module sia_dly #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] pipe_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        pipe_r[k] <= pipe_r[k-1];
      end
    end
  end

  assign q_o = pipe_r[DEPTH-1];

endmodule

// ===== rtl/sia_mul.sv =====
`timescale 1ns / 1ps
// sia_mul: four-stage 64x64 magnitude multiplier with signed 64-bit overflow check.
// Depends on sia_pkg.
module sia_mul (
  input  logic               clk,
  input  logic               en,
  input  logic [63:0]        a_i,
  input  logic [63:0]        b_i,
  input  logic               neg_i,
  output logic signed [63:0] p_o,
  output logic               ov_o
);
  import sia_pkg::*;

  logic [63:0]  pp00_r, pp01_r, pp10_r, pp11_r;
  logic         neg1_r, neg2_r, neg3_r;
  logic [64:0]  mid_r;
  logic [63:0]  lo2_r, hi2_r;
  logic [127:0] prod_r;
  logic [127:0] prod_nxt;
  logic [63:0]  lim;
  logic signed [63:0] p_r;
  logic         ov_r;

  assign prod_nxt = {hi2_r, lo2_r} + {31'd0, mid_r, 32'd0};
  assign lim      = neg3_r ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};

  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r <= a_i[31:0]  * b_i[31:0];
      pp01_r <= a_i[31:0]  * b_i[63:32];
      pp10_r <= a_i[63:32] * b_i[31:0];
      pp11_r <= a_i[63:32] * b_i[63:32];
      neg1_r <= neg_i;
      mid_r  <= {1'b0, pp01_r} + {1'b0, pp10_r};
      lo2_r  <= pp00_r;
      hi2_r  <= pp11_r;
      neg2_r <= neg1_r;
      prod_r <= prod_nxt;
      neg3_r <= neg2_r;
      ov_r   <= (|prod_r[127:64]) || (prod_r[63:0] > lim);
      p_r    <= neg3_r ? -$signed(prod_r[63:0]) : $signed(prod_r[63:0]);
    end
  end

  assign p_o  = p_r;
  assign ov_o = ov_r;

endmodule

// ===== rtl/sia_div.sv =====
`timescale 1ns / 1ps
// sia_div: 64-stage restoring divider on unsigned magnitudes, one quotient bit a stage.
// Depends on sia_pkg.
module sia_div (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] n_i,
  input  logic [63:0] d_i,
  output logic [63:0] q_o,
  output logic [63:0] r_o
);
  import sia_pkg::*;

  logic [63:0] rem_r [DIV_STAGES];
  logic [63:0] nq_r  [DIV_STAGES];
  logic [63:0] d_r   [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stg
    logic [63:0] rem_p, nq_p, d_p;
    logic [64:0] trial, diff;
    if (k == 0) begin : g_first
      assign rem_p = '0;
      assign nq_p  = n_i;
      assign d_p   = d_i;
    end else begin : g_next
      assign rem_p = rem_r[k-1];
      assign nq_p  = nq_r[k-1];
      assign d_p   = d_r[k-1];
    end
    assign trial = {rem_p, nq_p[63]};
    assign diff  = trial - {1'b0, d_p};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= diff[64] ? trial[63:0] : diff[63:0];
        nq_r[k]  <= {nq_p[62:0], ~diff[64]};
        d_r[k]   <= d_p;
      end
    end
  end

  assign q_o = nq_r[DIV_STAGES-1];
  assign r_o = rem_r[DIV_STAGES-1];

endmodule

// ===== rtl/sia_chk.sv =====
`timescale 1ns / 1ps
// sia_chk: port-level checks of the signed interval ALU, bound to the top level.
// Depends on signed_interval_alu.
module sia_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [63:0] out_result_min,
  input logic signed [63:0] out_result_max,
  input logic               out_is_bottom
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_min) &&
    $stable(out_result_max) && $stable(out_is_bottom))
    else $error("result changed under stall");

  a_bot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_bottom |-> out_result_min == 0 && out_result_max == 0)
    else $error("bottom result with nonzero bounds");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request refused with empty output");

  a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while pipeline frozen");

endmodule

bind signed_interval_alu sia_chk u_sia_chk (.*);

// ===== test/signed_interval_alu_tb.sv =====
`timescale 1ns / 1ps
// signed_interval_alu_tb: self-checking testbench of the signed interval ALU.
// Depends on sia_pkg and signed_interval_alu; predicts each result in SV and compares.
module signed_interval_alu_tb;
  import sia_pkg::*;

  typedef struct {
    logic [3:0]         op;
    logic signed [63:0] amin, amax, bmin, bmax;
    logic               aint, bint;
  } req_t;

  typedef struct {
    logic signed [63:0] lo, hi;
    logic               bot;
  } ival_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] in_operation = '0;
  logic signed [63:0] in_a_min = '0, in_a_max = '0, in_b_min = '0, in_b_max = '0;
  logic in_a_is_int = 1'b0, in_b_is_int = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [63:0] out_result_min, out_result_max;
  logic out_is_bottom;

  req_t  pending_reqs[$];
  ival_t expected_ivals[$];
  int    errors = 0;
  bit    calm = 1'b0;
  int    holdoff = 0;
  bit    holdoff_done = 1'b0;

  always #5 clk = ~clk;

  signed_interval_alu u_top (.*);

  function automatic ival_t mk(logic signed [63:0] lo, logic signed [63:0] hi);
    ival_t v;
    v.lo = lo; v.hi = hi; v.bot = 1'b0;
    return v;
  endfunction

  function automatic ival_t tri_state(bit yes, bit no);
    if (yes) return mk(1, 1);
    if (no) return mk(0, 0);
    return mk(0, 1);
  endfunction

  // exact product in 128 bits, overflow when it leaves the 64-bit range
  function automatic bit mul_wide(logic signed [63:0] a, logic signed [63:0] b,
                                  output logic signed [63:0] r);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    r = p[63:0];
    return p != 128'(r);
  endfunction

  function automatic ival_t span(logic signed [63:0] c0, logic signed [63:0] c1,
                                 logic signed [63:0] c2, logic signed [63:0] c3);
    logic signed [63:0] lo, hi;
    lo = c0; hi = c0;
    if (c1 < lo) lo = c1; if (c1 > hi) hi = c1;
    if (c2 < lo) lo = c2; if (c2 > hi) hi = c2;
    if (c3 < lo) lo = c3; if (c3 > hi) hi = c3;
    return mk(lo, hi);
  endfunction

  function automatic ival_t predict_interval(req_t q);
    logic signed [64:0] s0, s1;
    logic signed [63:0] c0, c1, c2, c3, m, al, ah, bl, bh;
    ival_t full, r;
    bit ov, apart, same;
    full = mk(S64_MIN, S64_MAX);
    al = q.amin; ah = q.amax; bl = q.bmin; bh = q.bmax;
    if (q.op <= OP_NOT && (!q.aint || (!(q.op == OP_NEG || q.op == OP_NOT) && !q.bint))) begin
      r = mk(0, 0); r.bot = 1'b1;
      return r;
    end
    apart = ah < bl || al > bh;
    same = al == ah && bl == bh && al == bl;
    case (q.op)
      OP_ADD: begin
        s0 = 65'(al) + 65'(bl); s1 = 65'(ah) + 65'(bh);
        if (s0 != 65'(64'(s0)) || s1 != 65'(64'(s1))) return full;
        return mk(s0[63:0], s1[63:0]);
      end
      OP_SUB: begin
        s0 = 65'(al) - 65'(bh); s1 = 65'(ah) - 65'(bl);
        if (s0 != 65'(64'(s0)) || s1 != 65'(64'(s1))) return full;
        return mk(s0[63:0], s1[63:0]);
      end
      OP_MUL: begin
        ov = mul_wide(al, bl, c0);
        ov |= mul_wide(al, bh, c1);
        ov |= mul_wide(ah, bl, c2);
        ov |= mul_wide(ah, bh, c3);
        return ov ? full : span(c0, c1, c2, c3);
      end
      OP_DIV: begin
        if ((bl <= 0 && bh >= 0) || bl == 0 || bh == 0) return full;
        if ((al == S64_MIN || ah == S64_MIN) && (bl == -1 || bh == -1)) return full;
        return span(al / bl, al / bh, ah / bl, ah / bh);
      end
      OP_MOD: begin
        if (bl != bh || bl == 0) return full;
        if (al == ah) begin
          if (bl == -1) return mk(0, 0);
          return mk(al % bl, al % bl);
        end
        m = (bl < 0 ? -bl : bl) - 1;
        if (al >= 0) return mk(0, m);
        if (ah <= 0) return mk(-m, 0);
        return mk(-m, m);
      end
      OP_EQ: return tri_state(!apart && same, apart);
      OP_NE: return tri_state(apart, same);
      OP_GT: return tri_state(al > bh, ah <= bl);
      OP_GE: return tri_state(al >= bh, ah < bl);
      OP_LT: return tri_state(ah < bl, al >= bh);
      OP_LE: return tri_state(ah <= bl, al > bh);
      OP_NEG: begin
        if (al == S64_MIN || ah == S64_MIN) return full;
        if (al == ah) return mk(-al, -al);
        return mk(-ah, -al);
      end
      OP_NOT: begin
        if (al == ah) return mk(al == 0, al == 0);
        return mk(0, 1);
      end
      default: return full;
    endcase
  endfunction

  function automatic logic signed [63:0] rand_bound();
    case ($urandom_range(0, 7))
      0: return S64_MIN + $urandom_range(0, 2);
      1: return S64_MAX - $urandom_range(0, 2);
      2: return {$urandom, $urandom};
      3: return $signed(64'($urandom_range(0, 20))) - 10;
      4: return $signed({{32{1'b0}}, $urandom}) - 64'sd2147483648;
      default: return $signed(64'($urandom_range(0, 2000))) - 1000;
    endcase
  endfunction

  task automatic add_req(logic [3:0] op, logic signed [63:0] amin, logic signed [63:0] amax,
                         logic signed [63:0] bmin, logic signed [63:0] bmax,
                         logic aint, logic bint);
    req_t q;
    q.op = op; q.amin = amin; q.amax = amax; q.bmin = bmin; q.bmax = bmax;
    q.aint = aint; q.bint = bint;
    pending_reqs.push_back(q);
  endtask

  task automatic report(string what, logic signed [63:0] got, logic signed [63:0] want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (in_valid && in_ready) expected_ivals.push_back(predict_interval(pending_reqs.pop_front()));
        if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 18)) begin
          in_valid <= 1'b1;
          in_operation <= pending_reqs[0].op;
          in_a_min <= pending_reqs[0].amin;
          in_a_max <= pending_reqs[0].amax;
          in_b_min <= pending_reqs[0].bmin;
          in_b_max <= pending_reqs[0].bmax;
          in_a_is_int <= pending_reqs[0].aint;
          in_b_is_int <= pending_reqs[0].bint;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    ival_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_ivals.size() == 0) begin
          report("unexpected result", out_result_min, 64'sd0);
        end else begin
          e = expected_ivals.pop_front();
          if (out_result_min !== e.lo) report("result_min", out_result_min, e.lo);
          if (out_result_max !== e.hi) report("result_max", out_result_max, e.hi);
          if (out_is_bottom !== e.bot) report("is_bottom", 64'(out_is_bottom), 64'(e.bot));
        end
      end
      if (!holdoff_done && pending_reqs.size() > 300) begin
        holdoff <= holdoff + 1;
        out_ready <= 1'b0;
        if (holdoff >= 200) holdoff_done <= 1'b1;
      end else begin
        out_ready <= calm || $urandom_range(0, 99) >= 18;
      end
    end
  end

  initial begin
    logic signed [63:0] x, y;
    logic [3:0] op;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    add_req(OP_ADD, S64_MAX, S64_MAX, 1, 1, 1, 1);
    add_req(OP_ADD, S64_MIN, S64_MAX, 0, 0, 1, 1);
    add_req(OP_SUB, S64_MIN, 5, 1, 1, 1, 1);
    add_req(OP_MUL, -3, 7, -5, 4, 1, 1);
    add_req(OP_MUL, S64_MIN, S64_MIN, -1, -1, 1, 1);
    add_req(OP_DIV, 100, 200, -5, 5, 1, 1);
    add_req(OP_DIV, S64_MIN, 0, -1, -1, 1, 1);
    add_req(OP_DIV, -100, 77, 3, 9, 1, 1);
    add_req(OP_MOD, -7, -7, 3, 3, 1, 1);
    add_req(OP_MOD, S64_MIN, S64_MIN, -1, -1, 1, 1);
    add_req(OP_MOD, 5, 9, 0, 0, 1, 1);
    add_req(OP_MOD, -5, 9, -4, -4, 1, 1);
    add_req(OP_MOD, 5, 9, 2, 4, 1, 1);
    add_req(OP_EQ, 4, 4, 4, 4, 1, 1);
    add_req(OP_NE, 1, 3, 5, 8, 1, 1);
    add_req(OP_GT, 9, 10, 1, 8, 1, 1);
    add_req(OP_GE, 1, 5, 5, 9, 1, 1);
    add_req(OP_LT, 1, 5, 3, 9, 1, 1);
    add_req(OP_LE, 1, 3, 3, 9, 1, 1);
    add_req(OP_NEG, S64_MIN, 0, 0, 0, 1, 0);
    add_req(OP_NEG, -9, -9, 0, 0, 1, 0);
    add_req(OP_NOT, 0, 0, 0, 0, 1, 0);
    add_req(OP_NOT, 10, 2, 0, 0, 1, 1);
    add_req(OP_ADD, 1, 2, 3, 4, 1, 0);
    add_req(4'd15, 1, 2, 3, 4, 0, 0);
    for (int i = 0; i < 700; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15)) : 4'($urandom_range(0, 12));
      x = rand_bound(); y = rand_bound();
      if ($urandom_range(0, 9) < 8 && x > y) begin x = y; y = rand_bound(); if (y < x) y = x; end
      if ($urandom_range(0, 4) == 0) y = x;
      add_req(op, x, y, rand_bound(), rand_bound(),
              $urandom_range(0, 15) != 0, $urandom_range(0, 15) != 0);
      if ($urandom_range(0, 2) == 0) begin
        pending_reqs[$].bmax = pending_reqs[$].bmin;
      end else if (pending_reqs[$].bmin > pending_reqs[$].bmax && $urandom_range(0, 4) != 0) begin
        x = pending_reqs[$].bmin;
        pending_reqs[$].bmin = pending_reqs[$].bmax;
        pending_reqs[$].bmax = x;
      end
    end
    wait (holdoff_done);
    repeat (150) @(posedge clk);
    calm = 1'b1;
    repeat (200) @(posedge clk);
    calm = 1'b0;
    wait (pending_reqs.size() == 0 && !in_valid && expected_ivals.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
